### design/ahrha_pkg.sv
package ahrha_pkg;

	typedef enum logic [1:0] {
		KIND_ALIGNED = 2'd0,
		KIND_FIXED   = 2'd1,
		KIND_FREE    = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] req_addr;
		logic [63:0] req_size;
		logic [63:0] align;
	} req_t;

	typedef struct packed {
		logic [63:0] result_addr;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_OPEN = 2'd1,
		CELL_DROP = 2'd2
	} cell_op_t;

	// Broadcast to every cell; each cell works out its own part from its select lines.
	typedef struct packed {
		cell_op_t    op;
		logic        wr_start;
		logic        wr_len;
		logic        wr_len2;
		logic [63:0] start;
		logic [63:0] len;
		logic [63:0] len2;
	} cell_cmd_t;

endpackage

### design/ahrha_cell.sv
module ahrha_cell
	import ahrha_pkg::*;
(
	input  logic        clk,
	input  cell_cmd_t   cmd,
	input  logic        sel,
	input  logic        sel2,
	input  logic        shift,
	input  logic [63:0] prev_start,
	input  logic [63:0] prev_len,
	input  logic [63:0] next_start,
	input  logic [63:0] next_len,
	output logic [63:0] start_q,
	output logic [63:0] len_q
);

	logic [63:0] start_d;
	logic [63:0] len_d;

	always_comb begin
		start_d = start_q;
		len_d   = len_q;
		if (shift) begin
			unique case (cmd.op)
				CELL_OPEN: begin
					start_d = prev_start;
					len_d   = prev_len;
				end
				CELL_DROP: begin
					start_d = next_start;
					len_d   = next_len;
				end
				default: ;
			endcase
		end
		if (sel && cmd.wr_start) start_d = cmd.start;
		if (sel && cmd.wr_len) len_d = cmd.len;
		if (sel2 && cmd.wr_len2) len_d = cmd.len2;
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		len_q   <= len_d;
	end

endmodule

### design/ahrha_rem.sv
module ahrha_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done_q,
	output logic [63:0] rem_q
);

	logic [6:0]  cnt_q;
	logic        run_q;
	logic [63:0] dvd_q;
	logic [64:0] trial;

	assign trial = {rem_q, dvd_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				dvd_q <= dividend;
				rem_q <= '0;
			end else if (run_q) begin
				// One quotient bit a cycle, restoring form.
				if (trial >= {1'b0, divisor}) rem_q <= 64'(trial - {1'b0, divisor});
				else rem_q <= trial[63:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
				cnt_q <= 7'(cnt_q + 7'd1);
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/address_range_hole_allocator.sv
// Free address range allocator. start is taken when busy is low; one result per transaction
// appears on result for a single cycle marked by done and cannot be held off. The hole table is
// a chain of cells, one hole each, sorted high to low; inserting or removing a hole shifts the
// cells after it along the chain. Requests are scanned one hole per cycle, except that an aligned
// allocation holds the scan while it runs the remainder unit for each hole large enough to hold
// the block. Seed the table with a free of the whole range.
module address_range_hole_allocator
	import ahrha_pkg::*;
#(
	parameter int MAX_HOLES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output logic done,
	output rsp_t result
);

	localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int CW = $clog2(MAX_HOLES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DIVW, S_CARVE, S_FIND, S_FREE_HI, S_FREE_LO
	} state_t;

	state_t      state_q;
	req_t        req_q;
	logic        top_q;
	logic [CW-1:0] cnt_q, i_q, idx_q;
	logic [63:0] s_q, l_q, base_q, l_hi_q;
	logic        hi_adj_q, done_q, go_q;
	rsp_t        res_q;
	logic [63:0] dvd_q;

	logic [63:0] st_a [MAX_HOLES];
	logic [63:0] ln_a [MAX_HOLES];

	logic [IW-1:0] rd_idx;
	logic [63:0]   rd_s, rd_l;
	logic [CW-1:0] scan_idx;
	cell_cmd_t     cmd;
	logic [CW-1:0] cmd_idx;
	status_t       app_st;
	logic          cnt_up, cnt_dn, full;
	logic          div_done;
	logic [63:0]   div_rem;
	logic [64:0]   req_end;
	logic          req_bad;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign full   = (cnt_q == CW'(MAX_HOLES));

	assign req_end = {1'b0, req.req_addr} + {1'b0, req.req_size};
	assign req_bad = (req.req_addr == 64'd0) || (req.req_size == 64'd0) ||
		(req_end[64] && (req_end[63:0] != 64'd0));

	assign scan_idx = (top_q || (req_q.kind != KIND_ALIGNED)) ? i_q
		: CW'(cnt_q - i_q - CW'(1));

	always_comb begin
		unique case (state_q)
			S_FREE_HI: rd_idx = IW'(i_q - CW'(1));
			S_SCAN:    rd_idx = IW'(scan_idx);
			default:   rd_idx = IW'(i_q);
		endcase
	end
	assign rd_s = st_a[rd_idx];
	assign rd_l = ln_a[rd_idx];

	// Table updates for a carve or a free, and the status they give.
	logic [63:0] below, above, gap_lo;
	logic        lo_ok, lo_bad, lo_adj;
	always_comb begin
		cmd     = '0;
		cmd.op  = CELL_HOLD;
		cmd_idx = idx_q;
		app_st  = ST_OK;
		cnt_up  = 1'b0;
		cnt_dn  = 1'b0;
		below   = base_q - s_q;
		above   = (l_q - req_q.req_size) - below;
		lo_ok   = (i_q < cnt_q);
		gap_lo  = req_q.req_addr - rd_s;
		lo_bad  = lo_ok && (rd_l > gap_lo);
		lo_adj  = lo_ok && (rd_l == gap_lo);
		if (state_q == S_CARVE) begin
			if (below == 64'd0 && above == 64'd0) begin
				cmd.op = CELL_DROP;
				cnt_dn = 1'b1;
			end else if (above == 64'd0) begin
				cmd.wr_len = 1'b1;
				cmd.len    = l_q - req_q.req_size;
			end else if (below == 64'd0) begin
				cmd.wr_start = 1'b1;
				cmd.start    = s_q + req_q.req_size;
				cmd.wr_len   = 1'b1;
				cmd.len      = l_q - req_q.req_size;
			end else if (full) begin
				app_st = ST_FULL;
			end else begin
				cmd.op       = CELL_OPEN;
				cmd.wr_start = 1'b1;
				cmd.start    = base_q + req_q.req_size;
				cmd.wr_len   = 1'b1;
				cmd.len      = above;
				cmd.wr_len2  = 1'b1;
				cmd.len2     = below;
				cnt_up       = 1'b1;
			end
		end else if (state_q == S_FREE_LO) begin
			if (lo_bad) begin
				app_st = ST_INVALID;
			end else if (lo_adj && hi_adj_q) begin
				// Free bridges two holes: the upper one goes, the lower one grows.
				cmd.op     = CELL_DROP;
				cmd_idx    = CW'(i_q - CW'(1));
				cmd.wr_len = 1'b1;
				cmd.len    = rd_l + req_q.req_size + l_hi_q;
				cnt_dn     = 1'b1;
			end else if (lo_adj) begin
				cmd_idx    = i_q;
				cmd.wr_len = 1'b1;
				cmd.len    = rd_l + req_q.req_size;
			end else if (hi_adj_q) begin
				cmd_idx      = CW'(i_q - CW'(1));
				cmd.wr_start = 1'b1;
				cmd.start    = req_q.req_addr;
				cmd.wr_len   = 1'b1;
				cmd.len      = l_hi_q + req_q.req_size;
			end else if (full) begin
				app_st = ST_FULL;
			end else begin
				cmd.op       = CELL_OPEN;
				cmd_idx      = i_q;
				cmd.wr_start = 1'b1;
				cmd.start    = req_q.req_addr;
				cmd.wr_len   = 1'b1;
				cmd.len      = req_q.req_size;
				cnt_up       = 1'b1;
			end
		end
	end

	for (genvar k = 0; k < MAX_HOLES; k++) begin : g_cell
		logic        sel, sel2, shift;
		logic [63:0] ps, pl, ns, nl;
		assign sel   = (cmd_idx == CW'(k));
		assign sel2  = (CW'(cmd_idx + CW'(1)) == CW'(k));
		assign shift = (cmd.op == CELL_OPEN) ? (CW'(k) > cmd_idx) : (CW'(k) >= cmd_idx);
		if (k == 0) begin : g_first
			assign ps = '0;
			assign pl = '0;
		end else begin : g_mid
			assign ps = st_a[k-1];
			assign pl = ln_a[k-1];
		end
		if (k == MAX_HOLES - 1) begin : g_last
			assign ns = '0;
			assign nl = '0;
		end else begin : g_inner
			assign ns = st_a[k+1];
			assign nl = ln_a[k+1];
		end
		ahrha_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.sel        (sel),
			.sel2       (sel2),
			.shift      (shift),
			.prev_start (ps),
			.prev_len   (pl),
			.next_start (ns),
			.next_len   (nl),
			.start_q    (st_a[k]),
			.len_q      (ln_a[k])
		);
	end

	ahrha_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (dvd_q),
		.divisor  (req_q.align),
		.done_q   (div_done),
		.rem_q    (div_rem)
	);

	logic [63:0] top_base, pad;
	assign top_base = dvd_q - div_rem;
	assign pad      = req_q.align - div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= 1'b1;
			cnt_q   <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
			go_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			if (cfg_we) top_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						i_q   <= '0;
						if (req.kind == KIND_ALIGNED) begin
							if (req.req_size == 64'd0 || req.align == 64'd0) begin
								done_q  <= 1'b1;
								res_q   <= {64'd0, ST_INVALID};
							end else begin
								state_q <= S_SCAN;
							end
						end else if ((req.kind == KIND_FIXED || req.kind == KIND_FREE)
							&& !req_bad) begin
							state_q <= (req.kind == KIND_FIXED) ? S_SCAN : S_FIND;
						end else begin
							done_q <= 1'b1;
							res_q  <= {64'd0, ST_INVALID};
						end
					end
				end
				S_SCAN: begin
					s_q   <= rd_s;
					l_q   <= rd_l;
					idx_q <= scan_idx;
					if (i_q == cnt_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= {64'd0, ST_NOFIT};
					end else if (req_q.kind == KIND_ALIGNED) begin
						if (req_q.req_size > rd_l) begin
							i_q <= CW'(i_q + CW'(1));
						end else begin
							dvd_q   <= top_q ? (rd_l - req_q.req_size) + rd_s : rd_s;
							go_q    <= 1'b1;
							state_q <= S_DIVW;
						end
					end else if (rd_s > req_q.req_addr) begin
						i_q <= CW'(i_q + CW'(1));
					end else if ((rd_l < req_q.req_addr - rd_s) ||
						(rd_l - (req_q.req_addr - rd_s) < req_q.req_size)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= {64'd0, ST_NOFIT};
					end else begin
						base_q  <= req_q.req_addr;
						state_q <= S_CARVE;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						if (top_q) begin
							if (top_base < s_q) begin
								i_q     <= CW'(i_q + CW'(1));
								state_q <= S_SCAN;
							end else begin
								base_q  <= top_base;
								state_q <= S_CARVE;
							end
						end else if (div_rem == 64'd0) begin
							base_q  <= s_q;
							state_q <= S_CARVE;
						end else if (pad > l_q - req_q.req_size) begin
							i_q     <= CW'(i_q + CW'(1));
							state_q <= S_SCAN;
						end else begin
							base_q  <= s_q + pad;
							state_q <= S_CARVE;
						end
					end
				end
				S_CARVE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					res_q   <= {(app_st == ST_OK) ? base_q : 64'd0, app_st};
					if (cnt_up) cnt_q <= CW'(cnt_q + CW'(1));
					if (cnt_dn) cnt_q <= CW'(cnt_q - CW'(1));
				end
				S_FIND: begin
					if (i_q < cnt_q && rd_s > req_q.req_addr) begin
						i_q <= CW'(i_q + CW'(1));
					end else begin
						hi_adj_q <= 1'b0;
						state_q  <= (i_q != '0) ? S_FREE_HI : S_FREE_LO;
					end
				end
				S_FREE_HI: begin
					l_hi_q <= rd_l;
					if (req_q.req_size > rd_s - req_q.req_addr) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= {64'd0, ST_INVALID};
					end else begin
						hi_adj_q <= (req_q.req_size == rd_s - req_q.req_addr);
						state_q  <= S_FREE_LO;
					end
				end
				S_FREE_LO: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					res_q   <= {64'd0, app_st};
					if (cnt_up) cnt_q <= CW'(cnt_q + CW'(1));
					if (cnt_dn) cnt_q <= CW'(cnt_q - CW'(1));
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/ahrha_checker.sv
module ahrha_checker
	import ahrha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	// A transaction that is taken either finishes at once or keeps the block busy.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("transaction taken but neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.result_addr == 64'd0)
		else $error("failed transaction returned an address");

	// Another result can only follow directly when a new transaction is taken at that edge.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !done)
		else $error("two results without a new transaction");

endmodule

bind address_range_hole_allocator ahrha_checker u_ahrha_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### sim/hole_checker.sv
`timescale 1ns / 100ps

module hole_checker
	import ahrha_pkg::*;
#(
	parameter int MAX_HOLES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        done,
	input  rsp_t        result,
	output int          fail_count,
	output int          pending,
	output int          responses_seen,
	output int          holes_now
);

	logic [63:0] hstart [MAX_HOLES];
	logic [63:0] hlen [MAX_HOLES];
	int          hcount;
	logic        top_mode;
	rsp_t        expected_q[$];

	assign holes_now = hcount;

	function automatic void remove_hole(int i);
		for (int k = i; k + 1 < hcount; k++) begin
			hstart[k] = hstart[k + 1];
			hlen[k] = hlen[k + 1];
		end
		hcount--;
	endfunction

	function automatic void make_room(int i);
		for (int k = hcount; k > i; k--) begin
			hstart[k] = hstart[k - 1];
			hlen[k] = hlen[k - 1];
		end
		hcount++;
	endfunction

	function automatic status_t take_range(int i, logic [63:0] base, logic [63:0] size);
		logic [63:0] lower;
		logic [63:0] upper;
		lower = base - hstart[i];
		upper = (hlen[i] - size) - lower;
		if (lower == 0 && upper == 0) remove_hole(i);
		else if (upper == 0) hlen[i] -= size;
		else if (lower == 0) begin
			hstart[i] += size;
			hlen[i] -= size;
		end else begin
			if (hcount >= MAX_HOLES) return ST_FULL;
			make_room(i);
			hstart[i] = base + size;
			hlen[i] = upper;
			hlen[i + 1] = lower;
		end
		return ST_OK;
	endfunction

	function automatic logic range_invalid(logic [63:0] a, logic [63:0] s);
		logic [63:0] e;
		e = a + s;
		if (a == 0 || s == 0) return 1'b1;
		return e != 0 && e < a;
	endfunction

	function automatic rsp_t predict_allocation(req_t r);
		rsp_t        o;
		logic [63:0] s;
		logic [63:0] l;
		logic [63:0] base;
		logic [63:0] pad;
		logic [63:0] d;
		logic [63:0] gap;
		int          idx;
		int          i;
		logic        lo_adj;
		logic        hi_adj;
		o.result_addr = '0;
		o.status = ST_NOFIT;
		case (kind_t'(r.kind))
			KIND_ALIGNED: begin
				if (r.req_size == 0 || r.align == 0) o.status = ST_INVALID;
				else for (i = 0; i < hcount; i++) begin
					idx = top_mode ? i : hcount - 1 - i;
					s = hstart[idx];
					l = hlen[idx];
					if (r.req_size > l) continue;
					if (top_mode) begin
						base = (l - r.req_size) + s;
						base -= base % r.align;
						if (base < s) continue;
					end else begin
						base = s;
						if (base % r.align != 0) begin
							pad = r.align - base % r.align;
							if (pad > l - r.req_size) continue;
							base += pad;
						end
					end
					o.status = take_range(idx, base, r.req_size);
					if (o.status == ST_OK) o.result_addr = base;
					break;
				end
			end
			KIND_FIXED: begin
				if (range_invalid(r.req_addr, r.req_size)) o.status = ST_INVALID;
				else for (i = 0; i < hcount; i++) begin
					if (hstart[i] > r.req_addr) continue;
					d = r.req_addr - hstart[i];
					if (hlen[i] < d || hlen[i] - d < r.req_size) break;
					o.status = take_range(i, r.req_addr, r.req_size);
					if (o.status == ST_OK) o.result_addr = r.req_addr;
					break;
				end
			end
			KIND_FREE: begin
				if (range_invalid(r.req_addr, r.req_size)) return '{'0, ST_INVALID};
				i = 0;
				while (i < hcount && hstart[i] > r.req_addr) i++;
				lo_adj = 1'b0;
				hi_adj = 1'b0;
				if (i > 0) begin
					gap = hstart[i - 1] - r.req_addr;
					if (r.req_size > gap) return '{'0, ST_INVALID};
					hi_adj = r.req_size == gap;
				end
				if (i < hcount) begin
					gap = r.req_addr - hstart[i];
					if (hlen[i] > gap) return '{'0, ST_INVALID};
					lo_adj = hlen[i] == gap;
				end
				o.status = ST_OK;
				if (lo_adj && hi_adj) begin
					hlen[i] += r.req_size + hlen[i - 1];
					remove_hole(i - 1);
				end else if (lo_adj) hlen[i] += r.req_size;
				else if (hi_adj) begin
					hstart[i - 1] = r.req_addr;
					hlen[i - 1] += r.req_size;
				end else if (hcount >= MAX_HOLES) o.status = ST_FULL;
				else begin
					make_room(i);
					hstart[i] = r.req_addr;
					hlen[i] = r.req_size;
				end
			end
			default: o.status = ST_INVALID;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			hcount <= 0;
			top_mode <= 1'b1;
			fail_count <= 0;
			responses_seen <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			// The result is compared before the new request, which cannot finish this cycle.
			if (done) begin
				responses_seen <= responses_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result addr=%h status=%0d", $time,
						result.result_addr, result.status);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = expected_q.pop_front();
					if (exp_rsp.result_addr !== result.result_addr ||
						exp_rsp.status !== result.status) begin
						$display("%0t: mismatch expected addr=%h status=%0d actual addr=%h status=%0d",
							$time, exp_rsp.result_addr, exp_rsp.status,
							result.result_addr, result.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) top_mode <= cfg_wdata;
			if (start && !busy) expected_q.push_back(predict_allocation(req));
			pending <= expected_q.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ahrha_pkg::*;

	localparam int MAX_HOLES = 32;
	localparam longint CYCLE_LIMIT = 10_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic done;
	rsp_t result;
	int   fail_count;
	int   pending;
	int   responses_seen;
	int   holes_now;
	int   items_sent = 0;
	longint cycles = 0;

	// Most addresses stay inside a small window so that holes collide and merge often.
	localparam logic [63:0] POOL_BASE = 64'h1000;
	localparam logic [63:0] POOL_SIZE = 64'h10000;

	address_range_hole_allocator #(.MAX_HOLES(MAX_HOLES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	hole_checker #(.MAX_HOLES(MAX_HOLES)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result),
		.fail_count(fail_count), .pending(pending), .responses_seen(responses_seen),
		.holes_now(holes_now)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// start stays high between back-to-back transactions; it drops only for a gap or when requests stop.
	task automatic send_request(kind_t k, logic [63:0] a, logic [63:0] s, logic [63:0] al);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= '{k, a, s, al};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic stop_requests();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain_and_configure(logic value);
		stop_requests();
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] wide_random();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pool_addr();
		return POOL_BASE + 64'($urandom_range(0, 32'hFFFF));
	endfunction

	function automatic logic [63:0] small_size();
		return $urandom_range(0, 7) == 0 ? 64'($urandom_range(1, 16'h2000))
			: 64'($urandom_range(1, 64));
	endfunction

	task automatic random_request();
		int pick;
		logic [63:0] al;
		pick = $urandom_range(0, 99);
		al = $urandom_range(0, 3) == 0 ? 64'($urandom_range(1, 100))
			: 64'(1) << $urandom_range(0, 8);
		if (pick < 2) send_request(kind_t'($urandom_range(0, 3)), wide_random(),
			wide_random(), wide_random());
		else if (pick < 4) send_request(KIND_ALIGNED, 0, small_size(),
			64'($urandom_range(0, 1)));
		else if (pick < 40) send_request(KIND_ALIGNED, 0, small_size(), al);
		else if (pick < 60) send_request(KIND_FIXED, pool_addr(), small_size(), 0);
		else send_request(KIND_FREE, pool_addr(), small_size(), 0);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Special cases, starting from an empty table; the whole range is seeded after them.
		send_request(KIND_ALIGNED, 0, 64'd16, 64'd1);
		send_request(KIND_FIXED, 64'h2000, 64'd16, 0);
		send_request(KIND_UNUSED, 64'h2000, 64'd16, 64'd1);
		send_request(KIND_FREE, 0, 64'd16, 0);
		send_request(KIND_FREE, 64'h10, 0, 0);
		send_request(KIND_FREE, '1, 64'd2, 0);
		send_request(KIND_FREE, 64'd1, '1, 0);
		send_request(KIND_ALIGNED, 0, 64'd8, '1);
		send_request(KIND_ALIGNED, 0, 64'd8, 64'd3);
		send_request(KIND_ALIGNED, 0, '1, 64'd1);
		send_request(KIND_FIXED, '1, 64'd1, 0);
		send_request(KIND_FREE, 64'h10, 64'h10, 0);
		send_request(KIND_FIXED, 64'h18, 64'h8, 0);
		send_request(KIND_FREE, 64'h18, 64'h8, 0);
		send_request(KIND_FREE, 64'h1, '1, 64'd0);
		send_request(KIND_FREE, 64'h2, 64'h4, 0);
		send_request(KIND_ALIGNED, 0, 64'd0, 64'd4);
		send_request(KIND_ALIGNED, 0, 64'd5, 64'd0);

		// Fill the table with scattered allocations until splits fail on a full table.
		drain_and_configure(1'b1);
		send_request(KIND_FREE, POOL_BASE, POOL_SIZE, 0);
		for (int i = 0; i < 40; i++)
			send_request(KIND_FIXED, POOL_BASE + 64'(i) * 64'h100 + 64'h10, 64'h8, 0);
		for (int i = 0; i < 8; i++)
			send_request(KIND_ALIGNED, 0, 64'h4, 64'h10);
		for (int i = 0; i < 40; i++)
			send_request(KIND_FREE, POOL_BASE + 64'(i) * 64'h100 + 64'h10, 64'h8, 0);

		for (int phase = 0; phase < 4; phase++) begin
			drain_and_configure(phase[0]);
			for (int i = 0; i < 140; i++) random_request();
		end
		drain_and_configure(1'b0);
		send_request(KIND_ALIGNED, 0, 64'd3, 64'd7);

		stop_requests();
		while (pending != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
		$display("Sent %0d requests, %0d results checked, %0d holes at the end.",
			items_sent, responses_seen, holes_now);
		$display("Covered both placement modes, table-full splits, merges and invalid requests.");
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
